/* rtl/rfcts_pkg.sv */
// ----------------------------------------------------------------------------
// rfcts_pkg: shared types and constants for the timestamp converter
// Beat types, the parsed-record type and the status codes.
// ----------------------------------------------------------------------------
package rfcts_pkg;

  function automatic int pow10(input int k);
    int p;
    p = 1;
    for (int i = 0; i < k; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

  // fraction digits kept, i.e. the output time unit is 10^-FracDigits s
  localparam int FracDigits = 6;
  localparam int Scale      = pow10(FracDigits);
  localparam int FracW      = $clog2(Scale);
  localparam int ScaleW     = $clog2(Scale + 1);
  localparam int FdW        = $clog2(FracDigits + 1);

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_TOO_SHORT    = 3'd1,
    ST_BAD_DATE     = 3'd2,
    ST_NO_T         = 3'd3,
    ST_BAD_TIME     = 3'd4,
    ST_NO_ZONE      = 3'd5,
    ST_BAD_DIGIT    = 3'd6,
    ST_TRUNC_OFFSET = 3'd7
  } status_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic signed [63:0] epoch_micros;
  } out_item_t;

  // one parsed timestamp, handed from the parser to the converter
  typedef struct packed {
    status_e          status;
    logic [13:0]      year;
    logic [3:0]       month;
    logic [6:0]       day;
    logic [6:0]       hour;
    logic [6:0]       minute;
    logic [6:0]       second;
    logic [FracW-1:0] frac;
    logic [FdW-1:0]   frac_digits;
    logic             off_neg;
    logic [6:0]       off_hours;
    logic [6:0]       off_minutes;
  } rec_t;

  // floor(x / 25) for x below 4096
  function automatic logic [7:0] div25(input logic [11:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd1311;
    return p[22:15];
  endfunction

  // days before the first of the month in a common year
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/rfc3339_timestamp_to_epoch_us.sv */
// ----------------------------------------------------------------------------
// rfc3339_timestamp_to_epoch_us: RFC 3339 text to UTC microseconds
// Takes one character per cycle unless full, back to back across strings;
// the parser closes a string on its last beat and queues the parsed record.
// Records go from the queue through the six-stage converter pipeline,
// giving one result per cycle, stalling only while a held output is unpopped.
// Reset clears the parse state, the record queue and the pipeline at once.
// ----------------------------------------------------------------------------
module rfc3339_timestamp_to_epoch_us
  import rfcts_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  logic accept;
  logic rec_wr;
  rec_t rec_in;
  logic rec_valid;
  rec_t rec_out;
  logic rec_pop;

  assign accept = push && !full;

  rfcts_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_item_i   (in_item_i),
    .rec_valid_o (rec_wr),
    .rec_o       (rec_in)
  );

  rfcts_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (rec_wr),
    .wr_data_i  (rec_in),
    .full_o     (full),
    .rd_valid_o (rec_valid),
    .rd_data_o  (rec_out),
    .rd_i       (rec_pop)
  );

  rfcts_convert u_convert (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (rec_valid),
    .rec_i       (rec_out),
    .rec_pop_o   (rec_pop),
    .empty_o     (empty),
    .out_item_o  (out_item_o),
    .pop_i       (pop)
  );

endmodule

/* rtl/rfcts_parser.sv */
// ----------------------------------------------------------------------------
// rfcts_parser: character front end
// Walks the timestamp text one character per beat, collects the fields and
// emits one parsed record with its status on the last character.
// ----------------------------------------------------------------------------
module rfcts_parser
  import rfcts_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t in_item_i,
  output logic     rec_valid_o,
  output rec_t     rec_o
);

  typedef enum logic [4:0] {
    PH_Y0, PH_Y1, PH_Y2, PH_Y3, PH_SEP1, PH_MON0, PH_MON1, PH_SEP2,
    PH_DAY0, PH_DAY1, PH_T, PH_HR0, PH_HR1, PH_COL1, PH_MIN0, PH_MIN1,
    PH_COL2, PH_SEC0, PH_SEC1, PH_AFTERSEC, PH_FRAC, PH_OH0, PH_OH1,
    PH_OCOL, PH_OM0, PH_OM1, PH_DONE
  } phase_e;

  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChDash   = 8'h2D;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChUpperT = 8'h54;
  localparam logic [7:0] ChLowerT = 8'h74;
  localparam logic [7:0] ChUpperZ = 8'h5A;
  localparam logic [7:0] ChLowerZ = 8'h7A;

  localparam logic [4:0] CountSat = 5'd20;

  function automatic logic [6:0] acc10(input logic [6:0] v, input logic [3:0] dg);
    return 7'(v * 7'd10 + 7'(dg));
  endfunction

  phase_e           phase_q, phase_d;
  status_e          err_q, err_d;
  logic [4:0]       cnt_q, cnt_d;
  logic [13:0]      year_q, year_d;
  logic [6:0]       month_q, month_d;
  logic [6:0]       day_q, day_d;
  logic [6:0]       hour_q, hour_d;
  logic [6:0]       min_q, min_d;
  logic [6:0]       sec_q, sec_d;
  logic [FracW-1:0] frac_q, frac_d;
  logic [FdW-1:0]   fd_q, fd_d;
  logic             neg_q, neg_d;
  logic [6:0]       oh_q, oh_d;
  logic [6:0]       om_q, om_d;

  logic [7:0] ch;
  logic       is_dig;
  logic [3:0] digit;
  logic [6:0] month_new;

  assign ch        = in_item_i.ch;
  assign is_dig    = (ch >= ChZero) && (ch <= ChNine);
  assign digit     = is_dig ? 4'(ch - ChZero) : 4'd0;
  assign month_new = acc10(month_q, digit);

  assign rec_valid_o = accept_i && in_item_i.last;

  always_comb begin
    phase_d = phase_q;
    err_d   = err_q;
    cnt_d   = cnt_q;
    year_d  = year_q;
    month_d = month_q;
    day_d   = day_q;
    hour_d  = hour_q;
    min_d   = min_q;
    sec_d   = sec_q;
    frac_d  = frac_q;
    fd_d    = fd_q;
    neg_d   = neg_q;
    oh_d    = oh_q;
    om_d    = om_q;

    if (accept_i) begin
      if (cnt_q < CountSat) begin
        cnt_d = cnt_q + 5'd1;
      end
      // after the first error the characters are only counted
      if (err_q == ST_OK) begin
        unique case (phase_q) inside
          PH_Y0, PH_Y1, PH_Y2, PH_Y3, PH_MON0, PH_MON1, PH_DAY0, PH_DAY1,
          PH_HR0, PH_HR1, PH_MIN0, PH_MIN1, PH_SEC0, PH_SEC1, PH_OH0, PH_OH1,
          PH_OM0, PH_OM1: begin
            if (!is_dig) begin
              err_d = ST_BAD_DIGIT;
            end else begin
              case (phase_q) inside
                [PH_Y0:PH_Y3]:    year_d = 14'(year_q * 14'd10 + 14'(digit));
                PH_MON0, PH_MON1: month_d = month_new;
                PH_DAY0, PH_DAY1: day_d = acc10(day_q, digit);
                PH_HR0, PH_HR1:   hour_d = acc10(hour_q, digit);
                PH_MIN0, PH_MIN1: min_d = acc10(min_q, digit);
                PH_SEC0, PH_SEC1: sec_d = acc10(sec_q, digit);
                PH_OH0, PH_OH1:   oh_d = acc10(oh_q, digit);
                default:          om_d = acc10(om_q, digit);
              endcase
              if (phase_q == PH_MON1 && (month_new == 7'd0 || month_new > 7'd12)) begin
                err_d = ST_BAD_DATE;
              end else begin
                phase_d = phase_e'(phase_q + 5'd1);
              end
            end
          end
          PH_SEP1, PH_SEP2: begin
            if (ch == ChDash) begin
              phase_d = phase_e'(phase_q + 5'd1);
            end else begin
              err_d = ST_BAD_DATE;
            end
          end
          PH_T: begin
            if (ch == ChUpperT || ch == ChLowerT) begin
              phase_d = PH_HR0;
            end else begin
              err_d = ST_NO_T;
            end
          end
          PH_COL1, PH_COL2: begin
            if (ch == ChColon) begin
              phase_d = phase_e'(phase_q + 5'd1);
            end else begin
              err_d = ST_BAD_TIME;
            end
          end
          PH_AFTERSEC, PH_FRAC: begin
            if (phase_q == PH_AFTERSEC && ch == ChDot) begin
              phase_d = PH_FRAC;
            end else if (phase_q == PH_FRAC && is_dig) begin
              // extra fraction digits are dropped
              if (fd_q < FdW'(FracDigits)) begin
                frac_d = FracW'(frac_q * FracW'(10) + FracW'(digit));
                fd_d   = fd_q + FdW'(1);
              end
            end else if (ch == ChUpperZ || ch == ChLowerZ) begin
              phase_d = PH_DONE;
            end else if (ch == ChPlus || ch == ChDash) begin
              neg_d   = (ch == ChDash);
              phase_d = PH_OH0;
            end else begin
              err_d = ST_NO_ZONE;
            end
          end
          PH_OCOL: begin
            // colon in the offset is optional
            if (ch == ChColon) begin
              phase_d = PH_OM0;
            end else if (is_dig) begin
              om_d    = 7'(digit);
              phase_d = PH_OM1;
            end else begin
              err_d = ST_BAD_DIGIT;
            end
          end
          default: ;
        endcase
      end
    end

    rec_o.year        = year_d;
    rec_o.month       = month_d[3:0];
    rec_o.day         = day_d;
    rec_o.hour        = hour_d;
    rec_o.minute      = min_d;
    rec_o.second      = sec_d;
    rec_o.frac        = frac_d;
    rec_o.frac_digits = fd_d;
    rec_o.off_neg     = neg_d;
    rec_o.off_hours   = oh_d;
    rec_o.off_minutes = om_d;
    if (cnt_d < CountSat) begin
      rec_o.status = ST_TOO_SHORT;
    end else if (err_d != ST_OK) begin
      rec_o.status = err_d;
    end else if (phase_d != PH_DONE) begin
      rec_o.status = (phase_d >= PH_OH0) ? ST_TRUNC_OFFSET : ST_NO_ZONE;
    end else begin
      rec_o.status = ST_OK;
    end

    // the string is finished: start over for the next one
    if (accept_i && in_item_i.last) begin
      phase_d = PH_Y0;
      err_d   = ST_OK;
      cnt_d   = '0;
      year_d  = '0;
      month_d = '0;
      day_d   = '0;
      hour_d  = '0;
      min_d   = '0;
      sec_d   = '0;
      frac_d  = '0;
      fd_d    = '0;
      neg_d   = 1'b0;
      oh_d    = '0;
      om_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_Y0;
      err_q   <= ST_OK;
      cnt_q   <= '0;
      year_q  <= '0;
      month_q <= '0;
      day_q   <= '0;
      hour_q  <= '0;
      min_q   <= '0;
      sec_q   <= '0;
      frac_q  <= '0;
      fd_q    <= '0;
      neg_q   <= 1'b0;
      oh_q    <= '0;
      om_q    <= '0;
    end else begin
      phase_q <= phase_d;
      err_q   <= err_d;
      cnt_q   <= cnt_d;
      year_q  <= year_d;
      month_q <= month_d;
      day_q   <= day_d;
      hour_q  <= hour_d;
      min_q   <= min_d;
      sec_q   <= sec_d;
      frac_q  <= frac_d;
      fd_q    <= fd_d;
      neg_q   <= neg_d;
      oh_q    <= oh_d;
      om_q    <= om_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && in_item_i.last |=> phase_q == PH_Y0 && cnt_q == '0 && err_q == ST_OK)
    else $error("parser state not cleared after last beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CountSat)
    else $error("character count past saturation");

endmodule

/* rtl/rfcts_queue.sv */
// ----------------------------------------------------------------------------
// rfcts_queue: record queue
// Short queue of parsed records between the parser and the converter.
// ----------------------------------------------------------------------------
module rfcts_queue
  import rfcts_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  rec_t wr_data_i,
  output logic full_o,
  output logic rd_valid_o,
  output rec_t rd_data_o,
  input  logic rd_i
);

  // power of two so the pointers wrap on their own
  localparam int QDepth = 4;
  localparam int PtrW   = $clog2(QDepth);
  localparam int CntW   = $clog2(QDepth + 1);

  rec_t            mem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_rd;

  assign full_o     = (cnt_q == CntW'(QDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_rd      = rd_i && rd_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (wr_i && !do_rd) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!wr_i && do_rd) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(QDepth))
    else $error("record queue count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni) wr_i |-> !full_o)
    else $error("record written into a full queue");

endmodule

/* rtl/rfcts_convert.sv */
// ----------------------------------------------------------------------------
// rfcts_convert: calendar to epoch pipeline
// Six-stage pipeline turning a parsed record into UTC time since 1970;
// the last stage is the output register, the whole pipe stalls with it.
// ----------------------------------------------------------------------------
module rfcts_convert
  import rfcts_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      rec_valid_i,
  input  rec_t      rec_i,
  output logic      rec_pop_o,
  output logic      empty_o,
  output out_item_t out_item_o,
  input  logic      pop_i
);

  localparam int DbyW  = 22;
  localparam int DaysW = 24;
  localparam int HmsW  = 21;
  localparam int SecsW = 41;

  // days from year 0 to 1970-01-01
  localparam int Dby1970 = 719528;
  localparam logic signed [SecsW-1:0] SecPerDay = SecsW'(86400);
  localparam logic [ScaleW-1:0]       ScaleC    = ScaleW'(Scale);

  logic adv;

  // stage a
  logic                a_vld_q;
  status_e             a_status_q;
  logic [13:0]         a_yr_q, a_nyr_q;
  logic [7:0]          a_qy_q, a_qn_q;
  logic [3:0]          a_month_q;
  logic [6:0]          a_day_q, a_hour_q, a_min_q, a_sec_q;
  logic [12:0]         a_tzmin_q;
  logic                a_neg_q;
  logic [FracW-1:0]    a_frac_q;
  // stage b
  logic                b_vld_q;
  status_e             b_status_q;
  logic signed [DaysW-1:0] b_days_q, b_days_d;
  logic signed [HmsW-1:0]  b_hms_q, b_hms_d;
  logic [FracW-1:0]    b_frac_q;
  // stage c
  logic                c_vld_q;
  status_e             c_status_q;
  logic signed [SecsW-1:0] c_secs_q, c_secs_d;
  logic [FracW-1:0]    c_frac_q;
  // stage d
  logic                d_vld_q;
  status_e             d_status_q;
  logic [63:0]         d_plo_q;
  logic [31:0]         d_shi_q;
  logic [FracW-1:0]    d_frac_q;
  // stage e
  logic                e_vld_q;
  status_e             e_status_q;
  logic [63:0]         e_plo_q;
  logic [31:0]         e_phi_q;
  logic [FracW-1:0]    e_frac_q;
  // stage f, output register
  logic                f_vld_q;
  status_e             f_status_q;
  logic [63:0]         f_res_q, f_res_d;

  assign adv        = !f_vld_q || pop_i;
  assign rec_pop_o  = adv && rec_valid_i;
  assign empty_o    = !f_vld_q;
  assign out_item_o.status       = f_status_q;
  assign out_item_o.epoch_micros = f_res_q;

  // stage a: year quotients, offset minutes, fraction padding
  logic [ScaleW-1:0]       pow_tab [FracDigits+1];
  logic [FdW-1:0]          pow_idx;
  logic [FracW+ScaleW-1:0] frac_prod;
  logic [13:0]             nyr;

  for (genvar g = 0; g <= FracDigits; g++) begin : g_pow
    assign pow_tab[g] = ScaleW'(pow10(g));
  end

  assign pow_idx   = FdW'(FracDigits) - rec_i.frac_digits;
  assign frac_prod = rec_i.frac * pow_tab[pow_idx];
  assign nyr       = rec_i.year - 14'd1;

  // stage b: day number and second of day
  logic [DbyW-1:0]         dby;
  logic                    leap;
  logic                    leap_add;
  logic signed [DaysW-1:0] dby_s, cum_s, day_s, adj_s;
  logic [HmsW-1:0]         hms_base, tz_sec;

  always_comb begin
    if (a_yr_q == '0) begin
      dby = '0;
    end else begin
      dby = DbyW'(a_yr_q * DbyW'(365)) + DbyW'(a_nyr_q[13:2]) - DbyW'(a_qn_q)
          + DbyW'(a_qn_q[7:2]) + DbyW'(1);
    end
    // divisible by 4, and not a century unless divisible by 400
    leap = (a_yr_q[1:0] == 2'b00)
        && ((a_yr_q[13:2] != 12'(a_qy_q * 12'd25)) || (a_qy_q[1:0] == 2'b00));
    leap_add = leap && (a_month_q > 4'd2);
    dby_s    = DaysW'(dby);
    cum_s    = DaysW'(cum_days(a_month_q));
    day_s    = DaysW'(a_day_q);
    adj_s    = DaysW'(leap_add);
    b_days_d = dby_s - DaysW'(Dby1970) + cum_s + adj_s + day_s - DaysW'(1);

    hms_base = HmsW'(a_hour_q) * HmsW'(3600) + HmsW'(a_min_q) * HmsW'(60) + HmsW'(a_sec_q);
    tz_sec   = HmsW'(a_tzmin_q) * HmsW'(60);
    b_hms_d  = a_neg_q ? (hms_base + tz_sec) : (hms_base - tz_sec);
  end

  // stage c: seconds since the epoch
  logic signed [SecsW-1:0] days_w, hms_w;
  assign days_w   = SecsW'(b_days_q);
  assign hms_w    = SecsW'(b_hms_q);
  assign c_secs_d = days_w * SecPerDay + hms_w;

  // stages d and e: scale to the output unit in two 32-bit halves
  logic [63:0]          secs64;
  logic [31+ScaleW:0]   d_prod, e_prod;
  assign secs64 = 64'(c_secs_q);
  assign d_prod = c_secs_q[31:0] * ScaleC;
  assign e_prod = d_shi_q * ScaleC;

  always_comb begin
    f_res_d = e_plo_q + {e_phi_q, 32'd0} + 64'(e_frac_q);
    if (e_status_q != ST_OK) begin
      f_res_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
      f_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= rec_valid_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
      e_vld_q <= d_vld_q;
      f_vld_q <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_status_q <= rec_i.status;
      a_yr_q     <= rec_i.year;
      a_nyr_q    <= nyr;
      a_qy_q     <= div25(rec_i.year[13:2]);
      a_qn_q     <= div25(nyr[13:2]);
      a_month_q  <= rec_i.month;
      a_day_q    <= rec_i.day;
      a_hour_q   <= rec_i.hour;
      a_min_q    <= rec_i.minute;
      a_sec_q    <= rec_i.second;
      a_tzmin_q  <= 13'(rec_i.off_hours) * 13'd60 + 13'(rec_i.off_minutes);
      a_neg_q    <= rec_i.off_neg;
      a_frac_q   <= FracW'(frac_prod);

      b_status_q <= a_status_q;
      b_days_q   <= b_days_d;
      b_hms_q    <= b_hms_d;
      b_frac_q   <= a_frac_q;

      c_status_q <= b_status_q;
      c_secs_q   <= c_secs_d;
      c_frac_q   <= b_frac_q;

      d_status_q <= c_status_q;
      d_plo_q    <= 64'(d_prod);
      d_shi_q    <= secs64[63:32];
      d_frac_q   <= c_frac_q;

      e_status_q <= d_status_q;
      e_plo_q    <= d_plo_q;
      e_phi_q    <= e_prod[31:0];
      e_frac_q   <= d_frac_q;

      f_status_q <= e_status_q;
      f_res_q    <= f_res_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_vld_q && f_status_q != ST_OK |-> f_res_q == '0)
    else $error("non-zero time on a failed conversion");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_vld_q && !pop_i |=> f_vld_q && $stable(f_status_q) && $stable(e_vld_q))
    else $error("pipeline moved while the output was held");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the RFC 3339 timestamp converter
// Streams timestamp text one character per beat, a directed table first and
// then random well-formed, damaged and noise strings, predicts each status and
// epoch in microseconds, and checks every result beat in order.
// ----------------------------------------------------------------------------
module tb_top;
  import rfcts_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_BEATS = 680;
  localparam int MAX_REPORTS  = 10;
  localparam int MIN_LENGTH   = 20;

  localparam int KEPT_DIGITS = FracDigits;
  localparam longint UNITS_PER_SEC = longint'(Scale);

  // parse positions
  localparam int PH_SEP1     = 4;
  localparam int PH_MON0     = 5;
  localparam int PH_SEP2     = 7;
  localparam int PH_DAY0     = 8;
  localparam int PH_T        = 10;
  localparam int PH_HR0      = 11;
  localparam int PH_COL1     = 13;
  localparam int PH_MIN0     = 14;
  localparam int PH_COL2     = 16;
  localparam int PH_SEC0     = 17;
  localparam int PH_AFTERSEC = 19;
  localparam int PH_FRAC     = 20;
  localparam int PH_OH0      = 21;
  localparam int PH_OH1      = 22;
  localparam int PH_OCOL     = 23;
  localparam int PH_OM0      = 24;
  localparam int PH_OM1      = 25;
  localparam int PH_DONE     = 26;

  logic      clk_i;
  logic      rst_ni     = 1'b0;
  logic      push       = 1'b0;
  logic      full;
  in_item_t  in_item_i  = '0;
  logic      empty;
  logic      pop        = 1'b0;
  out_item_t out_item_o;

  rfc3339_timestamp_to_epoch_us uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

  typedef struct {
    string   text;
    bit      typed;
    status_e status;
    longint  epoch;
  } stamp_row_t;

  localparam int NUM_ROWS = 26;
  stamp_row_t stamp_rows [NUM_ROWS] = '{
    '{"1970-01-01T00:00:00Z",             1'b1, ST_OK,           0},
    '{"1970-01-01T00:00:01Z",             1'b1, ST_OK,           1000000},
    '{"1969-12-31T23:59:59Z",             1'b1, ST_OK,           -1000000},
    '{"1970-01-01T00:00:00.000001Z",      1'b1, ST_OK,           1},
    '{"0000-01-01T00:00:00Z",             1'b0, ST_OK,           0},
    '{"9999-12-31T23:59:59.999999Z",      1'b0, ST_OK,           0},
    '{"2000-02-29T12:34:56.5+05:30",      1'b0, ST_OK,           0},
    '{"2024-03-01t00:00:00.1234567-0800", 1'b0, ST_OK,           0},
    '{"2001-09-09T01:46:40.z",            1'b0, ST_OK,           0},
    '{"1970-01-01T00:00:00Ztrailing text", 1'b1, ST_OK,          0},
    '{"2020-01-01T00:00:00+99:99",        1'b0, ST_OK,           0},
    '{"1999-01-00T99:99:99.000000-99:99", 1'b0, ST_OK,           0},
    '{"1970-01-01T00:00:00",              1'b1, ST_TOO_SHORT,    0},
    '{"X",                                1'b1, ST_TOO_SHORT,    0},
    '{"1999-00-10T00:00:00Z",             1'b1, ST_BAD_DATE,     0},
    '{"1999-13-10T00:00:00Z",             1'b1, ST_BAD_DATE,     0},
    '{"1999/01-10T00:00:00Z",             1'b1, ST_BAD_DATE,     0},
    '{"1999-13-10X00:00:00Z",             1'b1, ST_BAD_DATE,     0},
    '{"1999-01-10X00:00:00Z",             1'b1, ST_NO_T,         0},
    '{"1999-01-10T00-00:00Z",             1'b1, ST_BAD_TIME,     0},
    '{"19a9-01-10T00:00:00Z",             1'b1, ST_BAD_DIGIT,    0},
    '{"1999-01-10T00:00:00Q",             1'b1, ST_NO_ZONE,      0},
    '{"1999-01-10T00:00:00.5",            1'b1, ST_NO_ZONE,      0},
    '{"1999-01-10T00:00:00+05",           1'b1, ST_TRUNC_OFFSET, 0},
    '{"1999-01-10T00:00:00+05:3",         1'b1, ST_TRUNC_OFFSET, 0},
    '{"1999-01-10T00:00:00+05x00",        1'b1, ST_BAD_DIGIT,    0}
  };

  // parser image
  int          ts_phase;
  logic [4:0]  ts_count;
  logic [13:0] ts_year;
  logic [6:0]  ts_month, ts_day, ts_hour, ts_minute, ts_second;
  logic [19:0] ts_frac;
  logic [2:0]  ts_frac_n;
  logic        ts_off_neg;
  logic [6:0]  ts_off_hours, ts_off_minutes;
  status_e     ts_err;

  out_item_t   expected_stamps[$];
  logic [7:0]  text_q[$];

  bit          use_typed;
  out_item_t   typed_stamp;

  int          failures    = 0;
  int          idle_cycles = 0;
  int          beats_sent  = 0;
  int          burst_left  = 0;
  int          rx_cycle    = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic clear_parser();
    ts_phase       = 0;
    ts_count       = '0;
    ts_year        = '0;
    ts_month       = '0;
    ts_day         = '0;
    ts_hour        = '0;
    ts_minute      = '0;
    ts_second      = '0;
    ts_frac        = '0;
    ts_frac_n      = '0;
    ts_off_neg     = 1'b0;
    ts_off_hours   = '0;
    ts_off_minutes = '0;
    ts_err         = ST_OK;
  endtask

  task automatic flag_error(input status_e code);
    if (ts_err == ST_OK) ts_err = code;
  endtask

  function automatic bit numeric_phase(input int p);
    return p < PH_SEP1 || p == PH_MON0 || p == PH_MON0 + 1 || p == PH_DAY0 ||
           p == PH_DAY0 + 1 || p == PH_HR0 || p == PH_HR0 + 1 || p == PH_MIN0 ||
           p == PH_MIN0 + 1 || p == PH_SEC0 || p == PH_SEC0 + 1 || p == PH_OH0 ||
           p == PH_OH1 || p == PH_OM0 || p == PH_OM1;
  endfunction

  task automatic zone_char(input logic [7:0] c);
    if (c == "Z" || c == "z") begin
      ts_phase = PH_DONE;
    end else if (c == "+" || c == "-") begin
      ts_off_neg = (c == "-");
      ts_phase   = PH_OH0;
    end else begin
      flag_error(ST_NO_ZONE);
    end
  endtask

  task automatic parse_char(input logic [7:0] c);
    logic       dig;
    logic [3:0] d;
    dig = (c >= "0") && (c <= "9");
    d   = dig ? 4'(c - "0") : 4'd0;
    if (numeric_phase(ts_phase)) begin
      if (!dig) begin
        flag_error(ST_BAD_DIGIT);
      end else begin
        if (ts_phase < PH_SEP1) ts_year = 14'(ts_year * 14'd10 + 14'(d));
        else if (ts_phase <= PH_MON0 + 1) ts_month = 7'(ts_month * 7'd10 + 7'(d));
        else if (ts_phase <= PH_DAY0 + 1) ts_day = 7'(ts_day * 7'd10 + 7'(d));
        else if (ts_phase <= PH_HR0 + 1) ts_hour = 7'(ts_hour * 7'd10 + 7'(d));
        else if (ts_phase <= PH_MIN0 + 1) ts_minute = 7'(ts_minute * 7'd10 + 7'(d));
        else if (ts_phase <= PH_SEC0 + 1) ts_second = 7'(ts_second * 7'd10 + 7'(d));
        else if (ts_phase <= PH_OH1) ts_off_hours = 7'(ts_off_hours * 7'd10 + 7'(d));
        else ts_off_minutes = 7'(ts_off_minutes * 7'd10 + 7'(d));
        if (ts_phase == PH_MON0 + 1 && (ts_month < 1 || ts_month > 12)) begin
          flag_error(ST_BAD_DATE);
        end else begin
          ts_phase++;
          if (ts_phase == PH_OM1 + 1) ts_phase = PH_DONE;
        end
      end
    end else begin
      case (ts_phase)
        PH_SEP1, PH_SEP2: begin
          if (c != "-") flag_error(ST_BAD_DATE);
          else ts_phase++;
        end
        PH_T: begin
          if (c != "T" && c != "t") flag_error(ST_NO_T);
          else ts_phase++;
        end
        PH_COL1, PH_COL2: begin
          if (c != ":") flag_error(ST_BAD_TIME);
          else ts_phase++;
        end
        PH_AFTERSEC: begin
          if (c == ".") ts_phase = PH_FRAC;
          else zone_char(c);
        end
        PH_FRAC: begin
          if (dig) begin
            if (ts_frac_n < KEPT_DIGITS) begin
              ts_frac   = 20'(ts_frac * 20'd10 + 20'(d));
              ts_frac_n = ts_frac_n + 3'd1;
            end
          end else begin
            zone_char(c);
          end
        end
        PH_OCOL: begin
          // the colon in the offset is optional
          if (c == ":") begin
            ts_phase = PH_OM0;
          end else if (dig) begin
            ts_off_minutes = 7'(d);
            ts_phase       = PH_OM1;
          end else begin
            flag_error(ST_BAD_DIGIT);
          end
        end
        default: ;
      endcase
    end
  endtask

  function automatic bit leap_year(input int y);
    return (y % 4 == 0 && y % 100 != 0) || (y % 400 == 0);
  endfunction

  // days from the start of year zero, proleptic calendar
  function automatic longint days_before_year(input int y);
    longint r;
    r = 365 * longint'(y);
    if (y > 0) r += (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400 + 1;
    return r;
  endfunction

  function automatic int month_days(input int m);
    case (m)
      2:             return 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  function automatic longint micros_since_epoch();
    longint days, tz, secs, f;
    int     y;
    y    = int'(ts_year);
    days = days_before_year(y) - days_before_year(1970);
    for (int mo = 1; mo < int'(ts_month) && mo <= 12; mo++) begin
      days += month_days(mo);
      if (mo == 2 && leap_year(y)) days++;
    end
    days += longint'(ts_day) - 1;
    tz = longint'(ts_off_hours) * 60 + longint'(ts_off_minutes);
    if (ts_off_neg) tz = -tz;
    secs = days * 86400 + longint'(ts_hour) * 3600 + longint'(ts_minute) * 60 +
           longint'(ts_second) - tz * 60;
    f = longint'(ts_frac);
    for (int i = int'(ts_frac_n); i < KEPT_DIGITS; i++) f *= 10;
    return secs * UNITS_PER_SEC + f;
  endfunction

  task automatic take_char(input logic [7:0] c, input logic fin);
    out_item_t stamp;
    if (ts_count < MIN_LENGTH) ts_count = ts_count + 5'd1;
    if (ts_err == ST_OK) parse_char(c);
    if (fin) begin
      if (ts_count < MIN_LENGTH) stamp.status = ST_TOO_SHORT;
      else if (ts_err != ST_OK) stamp.status = ts_err;
      else if (ts_phase != PH_DONE && ts_phase >= PH_OH0) stamp.status = ST_TRUNC_OFFSET;
      else if (ts_phase != PH_DONE) stamp.status = ST_NO_ZONE;
      else stamp.status = ST_OK;
      stamp.epoch_micros = (stamp.status == ST_OK) ? micros_since_epoch() : 64'sd0;
      expected_stamps.push_back(use_typed ? typed_stamp : stamp);
      clear_parser();
    end
  endtask

  task automatic send_beat(input logic [7:0] c, input logic fin);
    int gap;
    push      <= 1'b1;
    in_item_i <= in_item_t'{ch: c, last: fin};
    do @(posedge clk_i); while (full);
    take_char(c, fin);
    beats_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 48);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_beat(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic put_number(input int v, input int n);
    int div;
    div = 1;
    for (int k = 1; k < n; k++) div *= 10;
    for (int k = 0; k < n; k++) begin
      text_q.push_back(8'("0" + (v / div) % 10));
      div /= 10;
    end
  endtask

  task automatic put_field(input int lo, input int hi);
    // mostly in range, now and then anything two digits allow
    put_number(($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(lo, hi), 2);
  endtask

  task automatic build_wellformed();
    int mon;
    text_q.delete();
    put_number(($urandom_range(0, 9) < 3) ? $urandom_range(1960, 1979) : $urandom_range(0, 9999), 4);
    text_q.push_back("-");
    mon = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
    put_number(mon, 2);
    text_q.push_back("-");
    put_field(1, 28);
    text_q.push_back($urandom_range(0, 3) == 0 ? "t" : "T");
    put_field(0, 23);
    text_q.push_back(":");
    put_field(0, 59);
    text_q.push_back(":");
    put_field(0, 60);
    if ($urandom_range(0, 1)) begin
      text_q.push_back(".");
      repeat ($urandom_range(0, 9)) text_q.push_back(8'("0" + $urandom_range(0, 9)));
    end
    case ($urandom_range(0, 3))
      0: text_q.push_back("Z");
      1: text_q.push_back("z");
      default: begin
        text_q.push_back($urandom_range(0, 1) ? "+" : "-");
        put_field(0, 14);
        if ($urandom_range(0, 2) != 0) text_q.push_back(":");
        put_field(0, 59);
      end
    endcase
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic build_random();
    int kind;
    kind = $urandom_range(0, 99);
    build_wellformed();
    if (kind >= 95) begin
      text_q.delete();
      repeat ($urandom_range(1, 30)) text_q.push_back(8'($urandom_range(0, 255)));
    end else if (kind >= 85) begin
      repeat (text_q.size() - $urandom_range(1, text_q.size())) void'(text_q.pop_back());
    end else if (kind >= 70) begin
      text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
    end
  endtask

  task automatic check_stamp(input out_item_t got);
    out_item_t want;
    if (expected_stamps.size() == 0) begin
      failures++;
      if (failures <= MAX_REPORTS)
        $display("unexpected result: status %0d epoch %0d",
                 got.status, $signed(got.epoch_micros));
    end else begin
      want = expected_stamps.pop_front();
      if (got.status !== want.status || got.epoch_micros !== want.epoch_micros) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("mismatch: expected status %0d epoch %0d, got status %0d epoch %0d",
                   want.status, $signed(want.epoch_micros),
                   got.status, $signed(got.epoch_micros));
      end
    end
  endtask

  // receiver: cycles through free-flowing, random, periodic and heavy stalling
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    case ((rx_cycle / 256) % 4)
      0:       pop <= 1'b1;
      1:       pop <= 1'($urandom_range(0, 1));
      2:       pop <= (rx_cycle % 13) < 9;
      default: pop <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (pop && !empty) check_stamp(out_item_o);
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    clear_parser();
    use_typed = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NUM_ROWS; r++) begin
      text_q.delete();
      for (int i = 0; i < stamp_rows[r].text.len(); i++) text_q.push_back(stamp_rows[r].text[i]);
      use_typed                = stamp_rows[r].typed;
      typed_stamp.status       = stamp_rows[r].status;
      typed_stamp.epoch_micros = stamp_rows[r].epoch;
      send_text();
    end
    use_typed = 1'b0;

    beats_sent = 0;
    while (beats_sent < RANDOM_BEATS) begin
      build_random();
      send_text();
    end
    push <= 1'b0;

    while (expected_stamps.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (failures == 0 && expected_stamps.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/rfcts_pkg.sv
rtl/rfcts_parser.sv
rtl/rfcts_queue.sv
rtl/rfcts_convert.sv
rtl/rfc3339_timestamp_to_epoch_us.sv
tb/sv/tb_top.sv
